// ----- rtl/qmp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and saturation helpers for the quintic motion profile unit
// no dependencies
package qmp_pkg;

  localparam int TIME_BITS_DEF = 24;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int INV_W         = 48;
  localparam int COEF_W        = 48;
  localparam int SCOEF_W       = 53;
  localparam int TAU_W         = 32;
  localparam int POS_W         = 32;
  localparam int VEL_W         = 32;
  localparam int ACC_W         = 48;
  localparam int OUT_W         = POS_W + VEL_W + ACC_W;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 2'd3;

  typedef enum logic [1:0] {
    CLS_BEFORE,
    CLS_AFTER,
    CLS_INSIDE
  } cls_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_COEF,
    DV_SCALE,
    DV_DIV
  } dv_state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  c1;
    logic signed [COEF_W-1:0]  c3;
    logic signed [COEF_W-1:0]  c4;
    logic signed [COEF_W-1:0]  c5;
    logic signed [SCOEF_W-1:0] c3x3;
    logic signed [SCOEF_W-1:0] c4x4;
    logic signed [SCOEF_W-1:0] c5x5;
    logic signed [SCOEF_W-1:0] c3x6;
    logic signed [SCOEF_W-1:0] c4x12;
    logic signed [SCOEF_W-1:0] c5x20;
  } coef_t;

  typedef struct packed {
    cls_t             cls;
    logic [TAU_W-1:0] tau;
  } qent_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      sat48 = hi[47:0];
    end else if (x < lo) begin
      sat48 = lo[47:0];
    end else begin
      sat48 = x[47:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      sat32 = hi[31:0];
    end else if (x < lo) begin
      sat32 = lo[31:0];
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ----- rtl/qmp_mulshr.sv -----
`timescale 1ns / 1ps
// four-stage signed by unsigned multiply, truncating shift toward zero, 64-bit clamp
// depends on nothing; split into four partial products of at most 32 by 24 bits
module qmp_mulshr #(
  parameter int AW = 48,
  parameter int BW = 32,
  parameter int SH = 32,
  parameter int OW = 48
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic signed [OW-1:0] y
);

  localparam int AH = (AW + 1) / 2;
  localparam int BH = (BW + 1) / 2;
  localparam int FW = 2 * (AH + BH);
  localparam int RW = FW - SH;

  logic              neg1, neg2, neg3;
  logic [2*AH-1:0]   mag1;
  logic [2*BH-1:0]   b1;
  logic [AH+BH-1:0]  p00, p01, p10, p11;
  logic [FW-1:0]     prod;
  logic [RW-1:0]     r;
  logic [63:0]       rc;
  logic [63:0]       y_full;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[AW-1];
      mag1 <= (2*AH)'(a[AW-1] ? AW'(-a) : AW'(a));
      b1   <= (2*BH)'(b);
      neg2 <= neg1;
      p00  <= mag1[AH-1:0]    * b1[BH-1:0];
      p01  <= mag1[AH-1:0]    * b1[2*BH-1:BH];
      p10  <= mag1[2*AH-1:AH] * b1[BH-1:0];
      p11  <= mag1[2*AH-1:AH] * b1[2*BH-1:BH];
      neg3 <= neg2;
      prod <= FW'(p00) + (FW'(p01) << BH) + (FW'(p10) << AH) + (FW'(p11) << (AH + BH));
      y    <= y_full[OW-1:0];
    end
  end

  assign r = prod[FW-1:SH];

  if (RW > 63) begin : g_clamp
    assign rc = (|r[RW-1:63]) ? {1'b0, {63{1'b1}}} : {1'b0, r[62:0]};
  end else begin : g_fit
    assign rc = 64'(r);
  end

  assign y_full = neg3 ? (64'd0 - rc) : rc;

endmodule

// ----- rtl/qmp_coef.sv -----
`timescale 1ns / 1ps
// configuration registers and coefficient derivation with a bit-serial reciprocal divider
// depends on qmp_pkg
module qmp_coef #(
  parameter int TIME_BITS = qmp_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qmp_pkg::CFG_W-1:0]        cfg_data,
  output logic signed [31:0]               len,
  output logic [TIME_BITS-1:0]             dur,
  output logic signed [31:0]               v0,
  output logic signed [31:0]               vf,
  output logic [qmp_pkg::INV_W-1:0]        inv,
  output qmp_pkg::coef_t                   coef,
  output logic                             busy
);
  import qmp_pkg::*;

  localparam int PRW = TIME_BITS + 25;
  localparam int MW  = 32 + TIME_BITS;

  dv_state_t           state, state_next;
  logic [5:0]          cnt;
  logic [TIME_BITS:0]  rem;
  logic [TIME_BITS:0]  rem_sh;
  logic                qbit;
  logic signed [PRW-1:0] p, f;
  logic [31:0]         v0_mag, vf_mag;
  logic [MW-1:0]       p_prod, f_prod;
  logic [PRW-1:0]      p_sh, f_sh;
  logic signed [63:0]  l64, p64, f64;
  logic signed [63:0]  a3, a4, a5;
  logic signed [SCOEF_W-1:0] s3, s4, s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE:  state_next = DV_IDLE;
      DV_MUL:   state_next = (dur == '0 || len == '0) ? DV_IDLE : DV_COEF;
      DV_COEF:  state_next = DV_SCALE;
      DV_SCALE: state_next = DV_DIV;
      DV_DIV:   state_next = (cnt == '0) ? DV_IDLE : DV_DIV;
      default:  state_next = DV_IDLE;
    endcase
    if (cfg_we) begin
      state_next = DV_MUL;
    end
  end

  assign busy = (state != DV_IDLE);

  assign v0_mag = v0[31] ? 32'(-v0) : 32'(v0);
  assign vf_mag = vf[31] ? 32'(-vf) : 32'(vf);
  assign p_prod = MW'(v0_mag) * MW'(dur);
  assign f_prod = MW'(vf_mag) * MW'(dur);
  assign p_sh   = PRW'(p_prod >> 8);
  assign f_sh   = PRW'(f_prod >> 8);

  assign l64 = 64'(len);
  assign p64 = 64'(p);
  assign f64 = 64'(f);
  assign a3  = (l64 <<< 3) + (l64 <<< 1) - ((p64 <<< 2) + (p64 <<< 1)) - (f64 <<< 2);
  assign a4  = (p64 <<< 3) + ((f64 <<< 3) - f64) - ((l64 <<< 4) - l64);
  assign a5  = (l64 <<< 2) + (l64 <<< 1) - ((p64 <<< 1) + p64) - ((f64 <<< 1) + f64);

  assign s3 = SCOEF_W'(coef.c3);
  assign s4 = SCOEF_W'(coef.c4);
  assign s5 = SCOEF_W'(coef.c5);

  assign rem_sh = {rem[TIME_BITS-1:0], 1'b1};
  assign qbit   = (rem_sh >= {1'b0, dur});

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      dur  <= '0;
      v0   <= '0;
      vf   <= '0;
      inv  <= '0;
      coef <= '0;
      cnt  <= '0;
      rem  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MOVE_LENGTH: len <= cfg_data;
          REG_MOVE_TICKS:  dur <= cfg_data[TIME_BITS-1:0];
          REG_START_SPEED: v0  <= cfg_data;
          REG_END_SPEED:   vf  <= cfg_data;
          default:         len <= len;
        endcase
      end else begin
        unique case (state)
          DV_MUL: begin
            p   <= v0[31] ? -$signed(p_sh) : $signed(p_sh);
            f   <= vf[31] ? -$signed(f_sh) : $signed(f_sh);
            inv <= '0;
            rem <= '0;
            cnt <= 6'(INV_W - 1);
            if (dur == '0 || len == '0) begin
              coef <= '0;
            end
          end
          DV_COEF: begin
            coef.c1 <= sat48(p64);
            coef.c3 <= sat48(a3);
            coef.c4 <= sat48(a4);
            coef.c5 <= sat48(a5);
          end
          DV_SCALE: begin
            coef.c3x3  <= (s3 <<< 1) + s3;
            coef.c4x4  <= s4 <<< 2;
            coef.c5x5  <= (s5 <<< 2) + s5;
            coef.c3x6  <= (s3 <<< 2) + (s3 <<< 1);
            coef.c4x12 <= (s4 <<< 3) + (s4 <<< 2);
            coef.c5x20 <= (s5 <<< 4) + (s5 <<< 2);
          end
          DV_DIV: begin
            rem <= qbit ? (rem_sh - {1'b0, dur}) : rem_sh;
            inv <= {inv[INV_W-2:0], qbit};
            cnt <= cnt - 6'd1;
          end
          default: cnt <= cnt;
        endcase
      end
    end
  end

endmodule

// ----- rtl/qmp_front.sv -----
`timescale 1ns / 1ps
// front end: accepts time samples, classifies them and forms tau = t * inv >> 16
// depends on qmp_pkg
module qmp_front #(
  parameter int TIME_BITS = qmp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [TIME_BITS-1:0]        sample_time,
  input  logic [TIME_BITS-1:0]        dur,
  input  logic [qmp_pkg::INV_W-1:0]   inv,
  input  logic                        busy,
  input  logic                        q_full,
  output logic                        q_push,
  output qmp_pkg::qent_t              q_data
);
  import qmp_pkg::*;

  localparam int TM = TIME_BITS - 1;
  localparam int IH = INV_W / 2;
  localparam int SW = TM + INV_W;

  logic [2:0]        vld;
  logic              adv, acc;
  cls_t              cls_in, cls1, cls2, cls3;
  logic [TM-1:0]     tmag1;
  logic [TM+IH-1:0]  plo, phi;
  logic [SW-1:0]     psum;
  logic [TAU_W-1:0]  tau3;

  assign adv      = !(vld[2] && q_full);
  assign in_ready = adv && !busy;
  assign acc      = in_valid && in_ready;
  assign q_push   = vld[2] && !q_full;
  assign q_data   = '{cls: cls3, tau: tau3};

  always_comb begin
    if (sample_time[TIME_BITS-1] || sample_time == '0) begin
      cls_in = CLS_BEFORE;
    end else if ({1'b0, sample_time[TM-1:0]} >= dur) begin
      cls_in = CLS_AFTER;
    end else begin
      cls_in = CLS_INSIDE;
    end
  end

  assign psum = SW'(plo) + (SW'(phi) << IH);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tmag1 <= sample_time[TM-1:0];
      cls1  <= cls_in;
      plo   <= tmag1 * inv[IH-1:0];
      phi   <= tmag1 * inv[INV_W-1:IH];
      cls2  <= cls1;
      tau3  <= psum[TAU_W+15:16];
      cls3  <= cls2;
    end
  end

endmodule

// ----- rtl/qmp_fifo.sv -----
`timescale 1ns / 1ps
// four-entry queue between the front end and the evaluation pipeline
// depends on qmp_pkg
module qmp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qmp_pkg::qent_t wdata,
  input  logic           pop,
  output qmp_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);
  import qmp_pkg::*;

  qent_t      mem [0:3];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- rtl/qmp_back.sv -----
`timescale 1ns / 1ps
// evaluation pipeline: tau powers, polynomial terms, reciprocal scaling, output register
// depends on qmp_pkg and qmp_mulshr
module qmp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  qmp_pkg::qent_t              q_data,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic signed [31:0]          len,
  input  logic signed [31:0]          v0,
  input  logic signed [31:0]          vf,
  input  logic [qmp_pkg::INV_W-1:0]   inv,
  input  qmp_pkg::coef_t              coef,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qmp_pkg::OUT_W-1:0]   out_data
);
  import qmp_pkg::*;

  logic [18:0]        vld;
  logic               adv;
  cls_t               cls_d [0:17];
  logic [TAU_W-1:0]   tau0, tau_1, tau_2, tau_3, tau_4;
  logic [TAU_W-1:0]   tau2_1, tau2_2, tau2_3, tau2_4;
  logic [TAU_W-1:0]   tau3_2, tau3_3, tau3_4;
  logic [TAU_W-1:0]   tau4_3, tau4_4;
  logic [TAU_W-1:0]   tau5_4;
  logic [2*TAU_W-1:0] m1, m2, m3, m4;
  logic signed [47:0] pp1, pp3, pp4, pp5;
  logic signed [51:0] dd3, dd4, dd5;
  logic signed [53:0] aa3, aa4, aa5;
  logic signed [49:0] pos_sum;
  logic signed [51:0] ds_sum;
  logic signed [53:0] d2_sum;
  logic signed [49:0] pos_d [0:7];
  logic signed [60:0] vel_y;
  logic signed [60:0] vel_d [0:3];
  logic signed [63:0] x_y, acc_y;

  assign adv       = !vld[18] || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = vld[18];

  assign m1 = tau0   * tau0;
  assign m2 = tau2_1 * tau_1;
  assign m3 = tau3_2 * tau_2;
  assign m4 = tau4_3 * tau_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[17:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_d[0] <= q_data.cls;
      for (int i = 1; i < 18; i++) begin
        cls_d[i] <= cls_d[i-1];
      end
      tau0   <= q_data.tau;
      tau_1  <= tau0;
      tau2_1 <= m1[2*TAU_W-1:TAU_W];
      tau_2  <= tau_1;
      tau2_2 <= tau2_1;
      tau3_2 <= m2[2*TAU_W-1:TAU_W];
      tau_3  <= tau_2;
      tau2_3 <= tau2_2;
      tau3_3 <= tau3_2;
      tau4_3 <= m3[2*TAU_W-1:TAU_W];
      tau_4  <= tau_3;
      tau2_4 <= tau2_3;
      tau3_4 <= tau3_3;
      tau4_4 <= tau4_3;
      tau5_4 <= m4[2*TAU_W-1:TAU_W];
      pos_sum <= 50'(pp1) + 50'(pp3) + 50'(pp4) + 50'(pp5);
      ds_sum  <= 52'(coef.c1) + dd3 + dd4 + dd5;
      d2_sum  <= aa3 + aa4 + aa5;
      pos_d[0] <= pos_sum;
      for (int i = 1; i < 8; i++) begin
        pos_d[i] <= pos_d[i-1];
      end
      vel_d[0] <= vel_y;
      for (int i = 1; i < 4; i++) begin
        vel_d[i] <= vel_d[i-1];
      end
      unique case (cls_d[17])
        CLS_BEFORE: out_data <= {ACC_W'(0), v0, POS_W'(0)};
        CLS_AFTER:  out_data <= {ACC_W'(0), vf, len};
        default:    out_data <= {sat48(acc_y), sat32(64'(vel_d[3])), sat32(64'(pos_d[7]))};
      endcase
    end
  end

  qmp_mulshr #(.AW(COEF_W), .BW(TAU_W), .SH(32), .OW(48)) u_p1 (
    .clk(clk), .en(adv), .a(coef.c1), .b(tau_4),  .y(pp1));
  qmp_mulshr #(.AW(COEF_W), .BW(TAU_W), .SH(32), .OW(48)) u_p3 (
    .clk(clk), .en(adv), .a(coef.c3), .b(tau3_4), .y(pp3));
  qmp_mulshr #(.AW(COEF_W), .BW(TAU_W), .SH(32), .OW(48)) u_p4 (
    .clk(clk), .en(adv), .a(coef.c4), .b(tau4_4), .y(pp4));
  qmp_mulshr #(.AW(COEF_W), .BW(TAU_W), .SH(32), .OW(48)) u_p5 (
    .clk(clk), .en(adv), .a(coef.c5), .b(tau5_4), .y(pp5));

  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(52)) u_d3 (
    .clk(clk), .en(adv), .a(coef.c3x3), .b(tau2_4), .y(dd3));
  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(52)) u_d4 (
    .clk(clk), .en(adv), .a(coef.c4x4), .b(tau3_4), .y(dd4));
  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(52)) u_d5 (
    .clk(clk), .en(adv), .a(coef.c5x5), .b(tau4_4), .y(dd5));

  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(54)) u_a3 (
    .clk(clk), .en(adv), .a(coef.c3x6),  .b(tau_4),  .y(aa3));
  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(54)) u_a4 (
    .clk(clk), .en(adv), .a(coef.c4x12), .b(tau2_4), .y(aa4));
  qmp_mulshr #(.AW(SCOEF_W), .BW(TAU_W), .SH(32), .OW(54)) u_a5 (
    .clk(clk), .en(adv), .a(coef.c5x20), .b(tau3_4), .y(aa5));

  qmp_mulshr #(.AW(52), .BW(INV_W), .SH(40), .OW(61)) u_vel (
    .clk(clk), .en(adv), .a(ds_sum), .b(inv), .y(vel_y));
  qmp_mulshr #(.AW(54), .BW(INV_W), .SH(24), .OW(64)) u_x (
    .clk(clk), .en(adv), .a(d2_sum), .b(inv), .y(x_y));
  qmp_mulshr #(.AW(64), .BW(INV_W), .SH(48), .OW(64)) u_acc (
    .clk(clk), .en(adv), .a(x_y), .b(inv), .y(acc_y));

endmodule

// ----- rtl/quintic_motion_profile_unit.sv -----
`timescale 1ns / 1ps
// a sample passes 3 front stages, the queue and 19 back stages on its way to the result
// throughput: one sample per cycle unless stalled; output stalls reach the front via a full queue
// a config write starts coefficient derivation with s_axis_tready low: multiply, coefficient,
// scaling, then the 48-step reciprocal divider (only multiply when duration or length is zero)
// rst is synchronous: config, coefficients and reciprocal clear to zero, pipelines empty
module quintic_motion_profile_unit #(
  parameter int TIME_BITS = qmp_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_time
  input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // position, velocity, acceleration
  output logic [qmp_pkg::OUT_W-1:0]           m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [qmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qmp_pkg::CFG_W-1:0]           cfg_data
);
  import qmp_pkg::*;

  logic signed [31:0]   len, v0, vf;
  logic [TIME_BITS-1:0] dur;
  logic [INV_W-1:0]     inv;
  coef_t                coef;
  logic                 busy;
  logic                 q_full, q_empty, q_push, q_pop;
  qent_t                q_wdata, q_rdata;

  qmp_coef #(.TIME_BITS(TIME_BITS)) u_coef (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .len(len), .dur(dur), .v0(v0), .vf(vf), .inv(inv), .coef(coef), .busy(busy));

  qmp_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sample_time(s_axis_tdata[TIME_BITS-1:0]), .dur(dur), .inv(inv), .busy(busy),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata));

  qmp_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty));

  qmp_back u_back (
    .clk(clk), .rst(rst), .q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
    .len(len), .v0(v0), .vf(vf), .inv(inv), .coef(coef),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata));

endmodule

// ----- tb/qmp_profile_checker.sv -----
`timescale 1ns / 1ps
// setpoint checker for quintic_motion_profile_unit: mirrors the profile registers,
// predicts position, velocity and acceleration per sample and compares results
// depends on qmp_pkg
module qmp_profile_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [qmp_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [qmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qmp_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            setpoints_checked
);
  import qmp_pkg::*;

  typedef struct packed {
    logic signed [47:0] acc;
    logic signed [31:0] vel;
    logic signed [31:0] pos;
  } setpoint_t;

  logic signed [31:0] move_length;
  logic [23:0]        move_ticks;
  logic signed [31:0] start_speed;
  logic signed [31:0] end_speed;
  longint             coef [4];
  longint unsigned    inv_ticks;
  setpoint_t          expected_setpoints [$];

  // trunc(a * b / 2^sh) toward zero, saturated to 64 bits
  function automatic longint scaled_product(longint a, longint unsigned b, int sh);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] r;
    mag  = (a < 0) ? (64'd0 - a) : a;
    prod = {64'd0, mag} * {64'd0, b};
    r    = prod >> sh;
    if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
    return (a < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic void derive_coefficients();
    longint len;
    longint p;
    longint f;
    len = move_length;
    if (move_ticks == 0 || len == 0) begin
      foreach (coef[i]) coef[i] = 0;
      inv_ticks = 0;
      return;
    end
    inv_ticks = 64'hFFFF_FFFF_FFFF / move_ticks;
    p = scaled_product(start_speed, move_ticks, 8);
    f = scaled_product(end_speed, move_ticks, 8);
    coef[0] = clamp(p, 48);
    coef[1] = clamp(10 * len - 6 * p - 4 * f, 48);
    coef[2] = clamp(-15 * len + 8 * p + 7 * f, 48);
    coef[3] = clamp(6 * len - 3 * p - 3 * f, 48);
  endfunction

  function automatic setpoint_t predict_setpoint(logic signed [23:0] sample);
    setpoint_t sp;
    longint t;
    longint unsigned tau, tau2, tau3, tau4, tau5;
    longint pos, ds, d2, vel, acc;
    t = sample;
    if (t <= 0) begin
      pos = 0;
      vel = start_speed;
      acc = 0;
    end else if (t >= longint'(move_ticks)) begin
      pos = move_length;
      vel = end_speed;
      acc = 0;
    end else begin
      tau  = (longint'(t) * inv_ticks) >> 16;
      tau2 = (tau * tau) >> 32;
      tau3 = (tau2 * tau) >> 32;
      tau4 = (tau3 * tau) >> 32;
      tau5 = (tau4 * tau) >> 32;
      pos = scaled_product(coef[0], tau, 32) + scaled_product(coef[1], tau3, 32)
          + scaled_product(coef[2], tau4, 32) + scaled_product(coef[3], tau5, 32);
      ds = coef[0] + scaled_product(3 * coef[1], tau2, 32)
         + scaled_product(4 * coef[2], tau3, 32) + scaled_product(5 * coef[3], tau4, 32);
      d2 = scaled_product(6 * coef[1], tau, 32) + scaled_product(12 * coef[2], tau2, 32)
         + scaled_product(20 * coef[3], tau3, 32);
      vel = scaled_product(ds, inv_ticks, 40);
      acc = scaled_product(scaled_product(d2, inv_ticks, 24), inv_ticks, 48);
    end
    sp.pos = clamp(pos, 32);
    sp.vel = clamp(vel, 32);
    sp.acc = clamp(acc, 48);
    return sp;
  endfunction

  always @(posedge clk) begin
    setpoint_t got;
    setpoint_t want;
    if (rst) begin
      move_length = 0;
      move_ticks  = 0;
      start_speed = 0;
      end_speed   = 0;
      derive_coefficients();
      expected_setpoints.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVE_LENGTH: move_length = cfg_data;
          REG_MOVE_TICKS:  move_ticks  = cfg_data[23:0];
          REG_START_SPEED: start_speed = cfg_data;
          REG_END_SPEED:   end_speed   = cfg_data;
          default: ;
        endcase
        derive_coefficients();
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_setpoints.push_back(predict_setpoint(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = setpoint_t'(m_axis_tdata);
        setpoints_checked <= setpoints_checked + 1;
        if (expected_setpoints.size() == 0) begin
          if (mismatches < 10) $display("checker: unexpected setpoint %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_setpoints.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("checker: pos exp %h got %h, vel exp %h got %h, acc exp %h got %h",
                       want.pos, got.pos, want.vel, got.vel, want.acc, got.acc);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_setpoints.size();
  end

endmodule

// ----- tb/tb_quintic_motion_profile_unit.sv -----
`timescale 1ns / 1ps
// top testbench for quintic_motion_profile_unit: drives profile settings and sample
// streams with random gaps and output stalls; checking lives in qmp_profile_checker
// depends on qmp_pkg, quintic_motion_profile_unit and qmp_profile_checker
module tb_quintic_motion_profile_unit;
  import qmp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MOVE_LENGTH;
  logic [CFG_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int setpoints_checked;
  int cycles = 0;
  int burst_left = 0;
  int samples_sent = 0;
  int settings_run = 0;
  int stall_mode = 0;

  quintic_motion_profile_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  qmp_profile_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .setpoints_checked(setpoints_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls: free-running, random, or mostly blocked, with the mode picked at random
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_sample(logic [23:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    samples_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic apply_setting(logic [31:0] len, logic [23:0] ticks,
                               logic [31:0] v0, logic [31:0] vf);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_MOVE_LENGTH, len);
    write_reg(REG_MOVE_TICKS, {8'd0, ticks});
    write_reg(REG_START_SPEED, v0);
    write_reg(REG_END_SPEED, vf);
    burst_left = 0;
    settings_run++;
  endtask

  task automatic random_samples(logic [23:0] ticks, int count);
    int kind;
    logic [23:0] t;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6 && ticks > 1)      t = 24'($urandom_range(1, ticks - 1));
      else if (kind < 7)              t = 24'($urandom);
      else if (kind < 9) begin
        case ($urandom_range(0, 3))
          0: t = 24'd0;
          1: t = ticks;
          2: t = ticks + 24'd1;
          default: t = ticks - 24'd1;
        endcase
      end else                        t = 24'(-$urandom_range(1, 1000));
      send_sample(t);
    end
  endtask

  initial begin
    logic [31:0] len, v0, vf;
    logic [23:0] ticks;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // reset profile is all zero
    send_sample(24'd0);
    send_sample(24'd5);
    send_sample(24'h800000);

    apply_setting(32'h0064_0000, 24'd1000, 32'h0000_0000, 32'h0000_0000);
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    send_sample(24'd1);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'd999);
    send_sample(24'd1000);
    send_sample(24'd1001);
    send_sample(24'd500);
    random_samples(24'd1000, 50);

    apply_setting(32'hFFCE_0000, 24'd1, 32'h0100_0000, 32'hFF80_0000);
    random_samples(24'd1, 30);
    apply_setting(32'h7FFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    random_samples(24'hFFFFFF, 60);
    apply_setting(32'h8000_0000, 24'd37, 32'h8000_0000, 32'h7FFF_FFFF);
    random_samples(24'd37, 60);
    apply_setting(32'h0000_0000, 24'd500, 32'h0040_0000, 32'h0020_0000);
    random_samples(24'd500, 40);
    repeat (4) begin
      len   = $urandom;
      ticks = 24'($urandom_range(2, 5000));
      v0    = $urandom;
      vf    = $urandom;
      if ($urandom_range(0, 1)) begin
        v0 = {{8{v0[31]}}, v0[23:0]};
        vf = {{8{vf[31]}}, vf[23:0]};
      end
      apply_setting(len, ticks, v0, vf);
      random_samples(ticks, 55);
    end
    apply_setting(32'h0100_0000, 24'd0, $urandom, $urandom);
    random_samples(24'd0, 30);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("tb: %0d samples over %0d profile settings, %0d setpoints checked, %0d mismatches",
             samples_sent, settings_run, setpoints_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
